### src/ilst_pkg.sv
// Shared types and codes for the indexed list engine.
// No dependencies; every other source file refers to this package by scope.
`default_nettype none
package ilst_pkg;

  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT     = 4'd2,
    OP_REM_BACK   = 4'd3,
    OP_REM_FRONT  = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_GET_BACK   = 4'd6,
    OP_GET_FRONT  = 4'd7,
    OP_GET_AT     = 4'd8,
    OP_SET_BACK   = 4'd9,
    OP_SET_FRONT  = 4'd10,
    OP_SET_AT     = 4'd11,
    OP_POP        = 4'd12,
    OP_CLEAR      = 4'd13
  } ilst_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ilst_status_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  position;
    logic [31:0] payload;
  } ilst_req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  length_now;
  } ilst_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } ilst_cmd_t;

endpackage
`default_nettype wire

### src/indexed_list_engine_unit.sv
// A request is captured into the request register, then a single execute step through the
// cell row and counter set writes the result register; no new request is taken until that
// step is done, and the execute step waits while a previous response is stalled.
// A new request is taken while the previous response still waits to be taken.
// Reset (rst_ni low, async) empties the list; stored values are not cleared.
// Depends on ilst_pkg, ilst_ctrl and ilst_dp.
`default_nettype none
module indexed_list_engine_unit #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ilst_pkg::ilst_req_t in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ilst_pkg::ilst_rsp_t      out_rsp_o
);

  ilst_pkg::ilst_cmd_t cmd;

  ilst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ilst_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o)
  );

endmodule
`default_nettype wire

### src/ilst_ctrl.sv
// Controller for the indexed list engine: handshake sequencing and output valid.
// Depends on ilst_pkg (command struct).
`default_nettype none
module ilst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ilst_pkg::ilst_cmd_t    cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    // result register must be empty or draining this cycle
    cmd_o.execute = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_o.execute) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### src/ilst_dp.sv
// Datapath for the indexed list engine: request register, shifting cell row,
// length counter and result register. Depends on ilst_pkg.
`default_nettype none
module ilst_dp #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ilst_pkg::ilst_cmd_t cmd_i,
  input  wire ilst_pkg::ilst_req_t in_req_i,
  output ilst_pkg::ilst_rsp_t      out_rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int IW = $clog2(CAPACITY);

  ilst_pkg::ilst_req_t   req_q;
  ilst_pkg::ilst_rsp_t   rsp_q, rsp_d;
  logic [VALUE_WIDTH-1:0] entries_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] entries_d [CAPACITY];
  logic [CW-1:0]          count_q, count_d;

  logic [63:0]            pay64;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [LW-1:0]          pos_l, cnt_l, last_l, tgt;
  logic [IW-1:0]          idx;
  logic                   empty;
  logic                   is_put, is_rem, is_get, is_set, by_pos;
  logic                   do_ins, do_rem, do_get, do_set;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [63:0]            rd64;
  logic [8:0]             len9;
  ilst_pkg::ilst_status_e st;

  assign pay64  = {32'd0, in_req_i.payload};
  assign pos_l  = LW'(req_q.position);
  assign cnt_l  = LW'(count_q);
  assign empty  = (count_q == '0);
  assign last_l = empty ? '0 : cnt_l - LW'(1);
  assign idx    = tgt[IW-1:0];

  // decode
  always_comb begin
    is_put = 1'b0;
    is_rem = 1'b0;
    is_get = 1'b0;
    is_set = 1'b0;
    by_pos = 1'b0;
    tgt    = '0;
    case (req_q.opcode)
      ilst_pkg::OP_PUSH_BACK:  begin is_put = 1'b1; tgt = cnt_l; end
      ilst_pkg::OP_PUSH_FRONT: begin is_put = 1'b1; end
      ilst_pkg::OP_INSERT:     begin is_put = 1'b1; tgt = pos_l; end
      ilst_pkg::OP_REM_BACK:   begin is_rem = 1'b1; tgt = last_l; end
      ilst_pkg::OP_REM_FRONT:  begin is_rem = 1'b1; end
      ilst_pkg::OP_REMOVE:     begin is_rem = 1'b1; by_pos = 1'b1; tgt = pos_l; end
      ilst_pkg::OP_GET_BACK:   begin is_get = 1'b1; tgt = last_l; end
      ilst_pkg::OP_GET_FRONT:  begin is_get = 1'b1; end
      ilst_pkg::OP_GET_AT:     begin is_get = 1'b1; by_pos = 1'b1; tgt = pos_l; end
      ilst_pkg::OP_SET_BACK:   begin is_set = 1'b1; tgt = last_l; end
      ilst_pkg::OP_SET_FRONT:  begin is_set = 1'b1; end
      ilst_pkg::OP_SET_AT:     begin is_set = 1'b1; by_pos = 1'b1; tgt = pos_l; end
      ilst_pkg::OP_POP:        begin is_get = 1'b1; is_rem = 1'b1; tgt = last_l; end
      default: ;
    endcase
  end

  // checks and actions
  always_comb begin
    st     = ilst_pkg::ST_OK;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_get = 1'b0;
    do_set = 1'b0;
    if (is_put) begin
      if (tgt > cnt_l) begin
        st = ilst_pkg::ST_RANGE;
      end else if (cnt_l == LW'(CAPACITY)) begin
        st = ilst_pkg::ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else if (is_rem || is_get || is_set) begin
      if (by_pos && (pos_l >= cnt_l)) begin
        st = ilst_pkg::ST_RANGE;
      end else if (!by_pos && empty) begin
        st = ilst_pkg::ST_EMPTY;
      end else begin
        do_rem = is_rem;
        do_get = is_get;
        do_set = is_set;
      end
    end
  end

  assign rd_val = do_get ? entries_q[idx] : '0;
  assign rd64   = 64'(rd_val);

  // cell row: each cell picks its neighbor, the new value, or itself
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if ((do_ins || do_set) && (LW'(i) == tgt)) begin
        entries_d[i] = val_q;
      end
    end
    if (do_ins) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (LW'(i) > tgt) begin
          entries_d[i] = entries_q[i-1];
        end
      end
    end
    if (do_rem) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (LW'(i) >= tgt) begin
          entries_d[i] = entries_q[i+1];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (req_q.opcode == ilst_pkg::OP_CLEAR) begin
      count_d = '0;
    end else if (do_ins) begin
      count_d = count_q + CW'(1);
    end else if (do_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  assign len9 = 9'(count_d);

  always_comb begin
    rsp_d.read_value = rd64[31:0];
    rsp_d.status     = st;
    rsp_d.length_now = len9[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
      val_q <= pay64[VALUE_WIDTH-1:0];
    end
    if (cmd_i.execute) begin
      entries_q <= entries_d;
      rsp_q     <= rsp_d;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule
`default_nettype wire

### src/ilst_checker.sv
// Port-level assertions for the indexed list engine, bound to the top level.
// Depends on ilst_pkg and indexed_list_engine_unit.
`default_nettype none
module ilst_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire ilst_pkg::ilst_req_t in_req_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ilst_pkg::ilst_rsp_t out_rsp_o
);

  // a stalled response stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // one request in flight: the cycle after acceptance the input is stalled
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is executing");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ilst_pkg::ST_EMPTY) |-> out_rsp_o.length_now == 5'd0)
    else $error("empty status with nonzero length");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ilst_pkg::ST_FULL)
      |-> out_rsp_o.length_now == 5'(CAPACITY))
    else $error("full status with length below capacity");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ilst_pkg::ST_OK) |-> out_rsp_o.read_value == 32'd0)
    else $error("error response carries a read value");

endmodule

bind indexed_list_engine_unit ilst_checker #(.CAPACITY(CAPACITY)) u_ilst_checker (.*);
`default_nettype wire
